### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the keyword parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define NKP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define NKP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/nkp_pkg.sv
// Types, keyword tables and helper functions for the command keyword parser.
package nkp_pkg;

  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 5;
  localparam int OFF_W    = 10;
  localparam int TLEN_W   = 4;
  localparam int NUM_KEYS = 20;
  localparam int NUM_VARS = 7;
  localparam int TEXT_W   = 16 * BYTE_W;

  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 5'd0;
  localparam logic [CODE_W-1:0] CODE_LIST     = 5'd11;
  localparam logic [CODE_W-1:0] CODE_MODE     = 5'd13;
  localparam logic [CODE_W-1:0] CODE_VAR_BASE = 5'd20;
  localparam logic [CODE_W-1:0] CODE_MAX      = 5'd26;

  localparam logic [TLEN_W-1:0] TLEN_MAX = 4'd15;

  // Strings are right-justified: character j of an L-character word sits at
  // byte L-1-j.
  localparam logic [TEXT_W-1:0] KEY_TEXT [NUM_KEYS] = '{
    "ARTICLE", "BODY", "CAPABILITIES", "DATE", "GROUP", "HDR", "HEAD",
    "HELP", "IHAVE", "LAST", "LIST", "LISTGROUP", "MODE", "NEWGROUPS",
    "NEWNEWS", "NEXT", "OVER", "POST", "QUIT", "STAT"
  };
  localparam logic [TLEN_W-1:0] KEY_LEN [NUM_KEYS] = '{
    4'd7, 4'd4, 4'd12, 4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd5, 4'd4,
    4'd4, 4'd9, 4'd4, 4'd9, 4'd7, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
  };

  // Entry 0 is READER (after MODE); the others are the LIST variants.
  localparam logic [TEXT_W-1:0] VAR_TEXT [NUM_VARS] = '{
    "READER", "ACTIVE", "ACTIVE.TIMES", "DISTRIB.PATS", "HEADERS",
    "NEWSGROUPS", "OVERVIEW.FMT"
  };
  localparam logic [TLEN_W-1:0] VAR_LEN [NUM_VARS] = '{
    4'd6, 4'd6, 4'd12, 4'd12, 4'd7, 4'd10, 4'd12
  };

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_GAP    = 2'd1,
    PH_SECOND = 2'd2,
    PH_TAIL   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] line_byte;
    logic              line_end;
  } nkp_step_t;

  typedef struct packed {
    logic [OFF_W-1:0]  argument_offset;
    logic [CODE_W-1:0] command_code;
  } nkp_result_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  // Character at position p of a right-justified word of length len.
  function automatic logic [BYTE_W-1:0] word_char(input logic [TEXT_W-1:0] text,
                                                  input logic [TLEN_W-1:0] len,
                                                  input logic [TLEN_W-1:0] p);
    logic [TLEN_W-1:0] sh;
    sh = len - 4'd1 - p;
    return text[BYTE_W*sh +: BYTE_W];
  endfunction

  function automatic logic [NUM_KEYS-1:0] key_filter(input logic [NUM_KEYS-1:0] m,
                                                     input logic [TLEN_W-1:0] tl,
                                                     input logic [BYTE_W-1:0] u);
    logic [NUM_KEYS-1:0] r;
    r = m;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (tl >= KEY_LEN[i] || word_char(KEY_TEXT[i], KEY_LEN[i], tl) != u) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [NUM_VARS-1:0] var_filter(input logic [NUM_VARS-1:0] m,
                                                     input logic [TLEN_W-1:0] tl,
                                                     input logic [BYTE_W-1:0] u);
    logic [NUM_VARS-1:0] r;
    r = m;
    for (int i = 0; i < NUM_VARS; i++) begin
      if (tl >= VAR_LEN[i] || word_char(VAR_TEXT[i], VAR_LEN[i], tl) != u) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] resolve_first(input logic [NUM_KEYS-1:0] m,
                                                      input logic [TLEN_W-1:0] tl);
    logic [CODE_W-1:0] code;
    code = CODE_UNKNOWN;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (m[i] && KEY_LEN[i] == tl) begin
        code = CODE_W'(i + 1);
      end
    end
    return code;
  endfunction

  function automatic logic [CODE_W-1:0] resolve_second(input logic [NUM_VARS-1:0] m,
                                                       input logic [TLEN_W-1:0] tl,
                                                       input logic [CODE_W-1:0] pend);
    logic [CODE_W-1:0] code;
    code = CODE_UNKNOWN;
    if (pend == CODE_MODE) begin
      code = (m[0] && VAR_LEN[0] == tl) ? CODE_MODE : CODE_UNKNOWN;
    end else begin
      for (int i = NUM_VARS - 1; i >= 1; i--) begin
        if (m[i] && VAR_LEN[i] == tl) begin
          code = CODE_VAR_BASE + CODE_W'(i);
        end
      end
    end
    return code;
  endfunction

endpackage

### rtl/nntp_command_keyword_parser.sv
// Top level of the command keyword parser: input register, parser, result register.
//
// Usage
//   s_axis: one byte of a command line per transfer; tlast marks the line's
//   last byte. m_axis: one result transfer per line, carrying the command
//   code (0 unknown, 1..20 keywords, 21..26 LIST variants) and the offset of
//   the first argument byte, or the examined line length if none.
// Result: the parse step runs while the line's last byte sits in the input
//   register, and its result is registered in the result register, from
//   which it is offered on m_axis.
// Throughput: one byte per cycle unless a last byte waits on a pending result;
//   every table word's current character is compared in parallel in the single parse step.
// Bytes from position MAX_LINE_BYTES on are accepted but not examined.
// Reset: clears both registers' valid flags and returns the parse state to
//   the start of a line.
// Stall: while the receiver holds m_axis_tready low, non-final bytes keep
//   flowing; only a line's last byte waits in the input register until the
//   pending result has been taken, and s_axis_tready then drops.
`include "assert_macros.svh"

module nntp_command_keyword_parser #(
  parameter int MAX_LINE_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [4:0] command_code, [14:5] argument_offset, [15] zero
);
  import nkp_pkg::*;

  // Input register
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  // Result register
  logic              out_valid_q, out_valid_d;
  nkp_result_t       out_res_q;

  logic              s_xfer;
  logic              out_free;
  logic              step_fire;
  nkp_step_t         step;
  logic              res_valid;
  nkp_result_t       res;

  assign s_xfer    = s_axis_tvalid & s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  // A non-final byte never produces a result, so it never waits on the output.
  assign step_fire = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || step_fire;

  assign step.line_byte = in_byte_q;
  assign step.line_end  = in_last_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  nkp_parser #(
    .MAX_LINE_BYTES(MAX_LINE_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step_fire),
    .step_i       (step),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.argument_offset, out_res_q.command_code};

  // Assertions
  `NKP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
  `NKP_ASSERT(a_code_range, m_axis_tvalid |-> (m_axis_tdata[4:0] <= CODE_MAX), "code out of range")
  `NKP_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(step_fire && in_last_q), "result without last byte")
  `NKP_ASSERT(a_stall_cause, (in_valid_q && !step_fire) |-> (in_last_q && out_valid_q), "input stalled without a pending result")

endmodule

### rtl/nkp_parser.sv
// Per-line parse state and the combinational byte step of the keyword parser.
module nkp_parser #(
  parameter int MAX_LINE_BYTES = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_valid_i,
  input  nkp_pkg::nkp_step_t  step_i,
  output logic                res_valid_o,
  output nkp_pkg::nkp_result_t res_o
);
  import nkp_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE_BYTES + 1);

  phase_e              phase_q, phase_d;
  logic [NUM_KEYS-1:0] kcand_q, kcand_d;
  logic [NUM_VARS-1:0] vcand_q, vcand_d;
  logic [TLEN_W-1:0]   tlen_q, tlen_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [CODE_W-1:0]   pend_q, pend_d;
  logic [POS_W-1:0]    offs_q, offs_d;
  logic                args_q, args_d;

  logic                ws;
  logic [BYTE_W-1:0]   u;
  logic                examine;
  logic [POS_W-1:0]    pos_inc;
  logic [TLEN_W-1:0]   tlen_inc;
  logic [CODE_W-1:0]   first_now;
  logic [CODE_W-1:0]   res_code;
  logic [POS_W-1:0]    res_off;

  assign ws        = is_ws(step_i.line_byte);
  assign u         = fold(step_i.line_byte);
  assign examine   = pos_q < POS_W'(MAX_LINE_BYTES);
  assign pos_inc   = pos_q + POS_W'(1);
  assign tlen_inc  = (tlen_q < TLEN_MAX) ? tlen_q + 4'd1 : tlen_q;
  assign first_now = resolve_first(kcand_q, tlen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      kcand_q <= '1;
      vcand_q <= '1;
      tlen_q  <= '0;
      pos_q   <= '0;
      pend_q  <= CODE_UNKNOWN;
      offs_q  <= '0;
      args_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      kcand_q <= kcand_d;
      vcand_q <= vcand_d;
      tlen_q  <= tlen_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      offs_q  <= offs_d;
      args_q  <= args_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    kcand_d  = kcand_q;
    vcand_d  = vcand_q;
    tlen_d   = tlen_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    offs_d   = offs_q;
    args_d   = args_q;
    res_code = CODE_UNKNOWN;
    res_off  = '0;

    if (step_valid_i) begin
      // Bytes past the line limit are not examined.
      if (examine) begin
        pos_d = pos_inc;
        unique case (phase_q)
          PH_FIRST: begin
            if (ws) begin
              pend_d = first_now;
              if (first_now == CODE_LIST || first_now == CODE_MODE) begin
                phase_d = PH_GAP;
              end else begin
                phase_d = PH_TAIL;
                offs_d  = pos_inc;
              end
            end else begin
              kcand_d = key_filter(kcand_q, tlen_q, u);
              tlen_d  = tlen_inc;
            end
          end
          PH_GAP: begin
            if (!ws) begin
              vcand_d = var_filter('1, '0, u);
              tlen_d  = 4'd1;
              phase_d = PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (ws) begin
              pend_d  = resolve_second(vcand_q, tlen_q, pend_q);
              phase_d = PH_TAIL;
              offs_d  = pos_inc;
            end else begin
              vcand_d = var_filter(vcand_q, tlen_q, u);
              tlen_d  = tlen_inc;
            end
          end
          PH_TAIL: begin
            if (!args_q) begin
              if (ws) begin
                offs_d = pos_inc;
              end else begin
                args_d = 1'b1;
              end
            end
          end
          default: begin
            phase_d = PH_FIRST;
          end
        endcase
      end

      // Line result, taken from the state after this byte.
      unique case (phase_d)
        PH_FIRST: begin
          res_code = resolve_first(kcand_d, tlen_d);
          if (res_code == CODE_MODE) begin
            res_code = CODE_UNKNOWN;
          end
          res_off = pos_d;
        end
        PH_GAP: begin
          res_code = (pend_d == CODE_LIST) ? CODE_LIST : CODE_UNKNOWN;
          res_off  = pos_d;
        end
        PH_SECOND: begin
          res_code = resolve_second(vcand_d, tlen_d, pend_d);
          res_off  = pos_d;
        end
        PH_TAIL: begin
          res_code = pend_d;
          res_off  = args_d ? offs_d : pos_d;
        end
        default: begin
          res_code = CODE_UNKNOWN;
        end
      endcase

      if (step_i.line_end) begin
        phase_d = PH_FIRST;
        kcand_d = '1;
        vcand_d = '1;
        tlen_d  = '0;
        pos_d   = '0;
        pend_d  = CODE_UNKNOWN;
        offs_d  = '0;
        args_d  = 1'b0;
      end
    end
  end

  assign res_valid_o           = step_valid_i & step_i.line_end;
  assign res_o.command_code    = res_code;
  assign res_o.argument_offset = OFF_W'(res_off);

endmodule
